// ===== sv/clsb_pkg.sv =====
// Shared constants, types and request codes for the character display shadow buffer.
// No dependencies; every other file imports this package.
`default_nettype none

package clsb_pkg;

  localparam int ROWS    = 5;
  localparam int COLS    = 9;
  localparam int CELLS   = ROWS * COLS;
  localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_MAX = 15;

  localparam logic [7:0] BLANK = 8'h20;

  typedef logic [CELL_W-1:0] cell_idx_t;

  typedef enum logic [2:0] {
    REQ_PUT   = 3'd0,
    REQ_BS    = 3'd1,
    REQ_GOTO  = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_SYNC  = 3'd4
  } req_t;

  // Contents of one display cell.
  typedef struct packed {
    logic [7:0] chr;
    logic       dirty;
  } cell_t;

  // One write into the cell memory.
  typedef struct packed {
    logic      we;
    cell_idx_t addr;
    cell_t     data;
  } mem_wr_t;

  // What an edit request does to the cell memory.
  typedef struct packed {
    mem_wr_t wr;
    logic    wipe;
  } edit_t;

endpackage

`default_nettype wire

// ===== sv/char_lcd_shadow_buffer.sv =====
// Character display shadow buffer: top level with the sync scan sequencer.
// Edit requests never raise busy. A sync holds busy while the scan reads memory once per cell,
// then through a drain state and a final state.
// Results are single-cycle strobes; the receiver cannot stall them. Each write is held until
// the next dirty cell or the end of the scan shows whether it is the last one.
// Reset is synchronous and needs no clearing pass: valid flops make every cell a dirty space.
// Depends on clsb_pkg, clsb_cell_mem and clsb_cursor.
`default_nettype none

module char_lcd_shadow_buffer
  import clsb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] req_type,
  input  wire logic [7:0] char_code,
  input  wire logic [3:0] target_row,
  input  wire logic [3:0] target_col,
  output logic            strobe,
  output logic            has_write,
  output logic [2:0]      write_row,
  output logic [3:0]      write_col,
  output logic [7:0]      write_char,
  output logic            last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  state_t     state;
  logic       go;
  edit_t      edit;
  mem_wr_t    scan_wr;
  mem_wr_t    mem_wr;
  logic       mem_re;
  cell_t      rdata;

  // Scan address and the row and column it stands for.
  cell_idx_t  scan_idx;
  logic [2:0] scan_row;
  logic [3:0] scan_col;

  // Cell whose read data is on rdata this cycle.
  logic       rd_pend;
  cell_idx_t  d_idx;
  logic [2:0] d_row;
  logic [3:0] d_col;

  // The most recent dirty cell found, not yet emitted.
  logic       hold_valid;
  logic [2:0] hold_row;
  logic [3:0] hold_col;
  logic [7:0] hold_char;

  logic       found;

  // A transaction is accepted whenever the scan is not running.
  assign go   = start && !busy;
  assign busy = (state != ST_IDLE);

  clsb_cursor u_cursor (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .req_type   (req_type),
    .char_code  (char_code),
    .target_row (target_row),
    .target_col (target_col),
    .edit       (edit)
  );

  // The scan reads one cell a cycle. A dirty cell is written back clean in the cycle after its
  // read, while the next cell is being read, so the two never touch the same entry.
  assign mem_re = (state == ST_SCAN);
  assign found  = rd_pend && rdata.dirty;

  always_comb begin
    scan_wr      = '0;
    scan_wr.we   = found;
    scan_wr.addr = d_idx;
    scan_wr.data = cell_t'{chr: rdata.chr, dirty: 1'b0};
  end

  // Edits are accepted only while the scan is idle, so the two write sources never collide.
  assign mem_wr = busy ? scan_wr : edit.wr;

  clsb_cell_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .wr    (mem_wr),
    .wipe  (edit.wipe),
    .re    (mem_re),
    .raddr (scan_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_pend    <= 1'b0;
      hold_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe  <= 1'b0;
      rd_pend <= (state == ST_SCAN);
      d_idx   <= scan_idx;
      d_row   <= scan_row;
      d_col   <= scan_col;

      // A newly found dirty cell releases the one held before it, which is then not last.
      if (found) begin
        if (hold_valid) begin
          strobe     <= 1'b1;
          has_write  <= 1'b1;
          write_row  <= hold_row;
          write_col  <= hold_col;
          write_char <= hold_char;
          last       <= 1'b0;
        end
        hold_valid <= 1'b1;
        hold_row   <= d_row;
        hold_col   <= d_col;
        hold_char  <= rdata.chr;
      end

      unique case (state)
        ST_IDLE: begin
          if (go && (req_type == REQ_SYNC)) begin
            state      <= ST_SCAN;
            scan_idx   <= '0;
            scan_row   <= 3'd0;
            scan_col   <= 4'd0;
            hold_valid <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_idx == CELL_W'(CELLS - 1)) begin
            state <= ST_DRAIN;
          end
          scan_idx <= scan_idx + CELL_W'(1);
          if (scan_col == 4'(COLS - 1)) begin
            scan_col <= 4'd0;
            scan_row <= scan_row + 3'd1;
          end else begin
            scan_col <= scan_col + 4'd1;
          end
        end
        ST_DRAIN: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          // Emit the final held write, or the empty result when nothing was dirty.
          state      <= ST_IDLE;
          strobe     <= 1'b1;
          has_write  <= hold_valid;
          write_row  <= hold_valid ? hold_row : 3'd0;
          write_col  <= hold_valid ? hold_col : 4'd0;
          write_char <= hold_valid ? hold_char : 8'd0;
          last       <= 1'b1;
          hold_valid <= 1'b0;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The closing result of a sync is shown just as the sequencer returns to idle.
  a_last_at_idle : assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> (state == ST_IDLE))
    else $error("last result shown while the scan is still running");

  // An empty result is always the only and final result of its sync.
  a_empty_is_last : assert property (@(posedge clk) disable iff (rst)
    (strobe && !has_write) |-> last)
    else $error("empty sync result not marked last");

  // Edit requests never produce a result.
  a_edit_silent : assert property (@(posedge clk) disable iff (rst)
    (go && (req_type != REQ_SYNC)) |=> !strobe)
    else $error("result produced by an edit request");

  // Only an accepted sync transaction starts the scan.
  a_busy_from_sync : assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(go && (req_type == REQ_SYNC)))
    else $error("scan started without a sync request");

endmodule

`default_nettype wire

// ===== sv/clsb_cell_mem.sv =====
// Cell memory: character and dirty bit per cell, one write and one registered read port.
// Valid flops overlay the reset contents (dirty space). Depends on clsb_pkg.
`default_nettype none

module clsb_cell_mem
  import clsb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire mem_wr_t   wr,
  input  wire logic      wipe,
  input  wire logic      re,
  input  wire cell_idx_t raddr,
  output cell_t          rdata
);

  cell_t            mem [CELLS];
  logic [CELLS-1:0] valid;
  cell_t            rd_raw;
  logic             rd_hit;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (re) begin
      rd_raw <= mem[raddr];
    end
  end

  // An entry that was never written since reset or clear reads as a dirty space.
  always_ff @(posedge clk) begin
    if (rst || wipe) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (re) begin
        rd_hit <= valid[raddr];
      end
      if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_hit ? rd_raw : cell_t'{chr: BLANK, dirty: 1'b1};

endmodule

`default_nettype wire

// ===== sv/clsb_cursor.sv =====
// Cursor registers and the edit requests: put char, backspace, goto and clear.
// Produces the single cell write or wipe an edit causes. Depends on clsb_pkg.
`default_nettype none

module clsb_cursor
  import clsb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire logic [2:0] req_type,
  input  wire logic [7:0] char_code,
  input  wire logic [3:0] target_row,
  input  wire logic [3:0] target_col,
  output edit_t           edit
);

  logic [3:0] cursor_row, cursor_row_next;
  logic [3:0] cursor_col, cursor_col_next;
  logic [3:0] bs_row, bs_col;
  logic       put_wrap;

  function automatic logic on_screen(logic [3:0] r, logic [3:0] c);
    return (5'(r) < 5'(ROWS)) && (5'(c) < 5'(COLS));
  endfunction

  function automatic cell_idx_t cell_index(logic [3:0] r, logic [3:0] c);
    logic [7:0] idx;
    idx = 8'(r) * 8'(COLS) + 8'(c);
    return idx[CELL_W-1:0];
  endfunction

  assign put_wrap = (5'(cursor_col) + 5'd1) >= 5'(COLS);

  always_comb begin
    bs_row = cursor_row;
    bs_col = cursor_col;
    if (cursor_col != 4'd0) begin
      bs_col = cursor_col - 4'd1;
    end else if (cursor_row != 4'd0) begin
      bs_row = cursor_row - 4'd1;
      bs_col = 4'(COLS - 1);
    end
  end

  always_comb begin
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    edit            = '0;
    if (go) begin
      unique case (req_t'(req_type))
        REQ_PUT: begin
          edit.wr.we   = on_screen(cursor_row, cursor_col);
          edit.wr.addr = cell_index(cursor_row, cursor_col);
          edit.wr.data = cell_t'{chr: char_code, dirty: 1'b1};
          if (put_wrap) begin
            cursor_col_next = 4'd0;
            if (cursor_row != 4'(ROW_MAX)) begin
              cursor_row_next = cursor_row + 4'd1;
            end
          end else begin
            cursor_col_next = cursor_col + 4'd1;
          end
        end
        REQ_BS: begin
          cursor_row_next = bs_row;
          cursor_col_next = bs_col;
          edit.wr.we      = on_screen(bs_row, bs_col);
          edit.wr.addr    = cell_index(bs_row, bs_col);
          edit.wr.data    = cell_t'{chr: BLANK, dirty: 1'b1};
        end
        REQ_GOTO: begin
          cursor_row_next = target_row;
          cursor_col_next = target_col;
        end
        REQ_CLEAR: begin
          cursor_row_next = 4'd0;
          cursor_col_next = 4'd0;
          edit.wipe       = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= 4'd0;
      cursor_col <= 4'd0;
    end else begin
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
    end
  end

endmodule

`default_nettype wire
